@@ rtl/core/heightmap_normal_stream_assert.svh @@
// ----------------------------------------------------------------------------
// Assertion macros for the heightmap normal stream
// Each macro expects clk and rst in the scope where it is used.
// ----------------------------------------------------------------------------
`ifndef HEIGHTMAP_NORMAL_STREAM_ASSERT_SVH
`define HEIGHTMAP_NORMAL_STREAM_ASSERT_SVH

// Same-cycle implication
`define HNS_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication
`define HNS_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ rtl/core/hns_pkg.sv @@
// ----------------------------------------------------------------------------
// hns_pkg: shared types and constants
// Widths, register codes, sequencer states and unit interface structs.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package hns_pkg;

  localparam int MAX_WIDTH  = 1024;
  localparam int MAX_HEIGHT = 4096;
  localparam int COL_W      = $clog2(MAX_WIDTH);
  localparam int ROW_W      = $clog2(MAX_HEIGHT);
  localparam int SAMPLE_W   = 16;
  localparam int DIFF_W     = 18;
  localparam int MAG_W      = 15;
  localparam int NORM_W     = 16;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;
  localparam int MW_W       = 11;
  localparam int MH_W       = 13;
  localparam int SCALE_W    = 16;

  localparam logic [MW_W-1:0]    WIDTH_RESET  = 11'd100;
  localparam logic [MH_W-1:0]    HEIGHT_RESET = 13'd100;
  localparam logic [SCALE_W-1:0] SCALE_RESET  = 16'd51;

  // Configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_MAP_WIDTH    = 2'd0,
    REG_MAP_HEIGHT   = 2'd1,
    REG_NORMAL_SCALE = 2'd2
  } cfg_reg_t;

  // Item sequencer
  typedef enum logic [3:0] {
    ST_IDLE, ST_RD0, ST_RD1, ST_RD2, ST_RD3,
    ST_PICK, ST_CALC, ST_PUSH, ST_WR0, ST_WR1
  } seq_state_t;

  // Normalization unit
  typedef enum logic [3:0] {
    NS_IDLE, NS_MULX, NS_MULZ, NS_SHIFT, NS_SQX, NS_SQY, NS_SQZ,
    NS_ROOT, NS_DIVLD, NS_DIV, NS_DONE
  } norm_state_t;

  typedef struct packed {
    logic signed [DIFF_W-1:0] dx;
    logic signed [DIFF_W-1:0] dz;
  } norm_req_t;

  typedef struct packed {
    logic [MAG_W-1:0] mag_x;
    logic [MAG_W-1:0] mag_y;
    logic [MAG_W-1:0] mag_z;
    logic             neg_x;
    logic             neg_z;
  } norm_rsp_t;

endpackage

@@ rtl/core/hns_ram.sv @@
// ----------------------------------------------------------------------------
// hns_ram: generic simple dual-port RAM
// One write port, one read port, registered read data.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module hns_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

@@ rtl/core/hns_norm.sv @@
// ----------------------------------------------------------------------------
// hns_norm: iterative normal vector unit
// Scales the slopes with one shared multiplier, takes an integer root one bit
// a step and divides each component one quotient bit a step.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module hns_norm (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  input  hns_pkg::norm_req_t req,
  input  logic [15:0]       scale,
  output logic              done,
  output hns_pkg::norm_rsp_t rsp
);
  import hns_pkg::*;

  norm_state_t state, state_next;

  logic [16:0] ax, az;
  logic        neg_x, neg_z;
  logic [33:0] gx, gz;
  logic [18:0] gy;
  logic [61:0] acc;
  logic [61:0] sq_v, sq_res, sq_bit;
  logic [1:0]  sel;
  logic [31:0] rem;
  logic [15:0] nlow, q;
  logic [3:0]  cnt;
  logic [MAG_W-1:0] rx, ry, rz;

  logic [17:0] abs_dx, abs_dz;
  logic [16:0] s2;
  logic [29:0] mul_a, mul_b;
  logic [59:0] mul_p;
  logic        over;
  logic [61:0] trial;
  logic        root_ge;
  logic [30:0] len;
  logic [29:0] mag;
  logic [45:0] num;
  logic [32:0] rem_sh, div_d;
  logic        div_ge;
  logic [31:0] rem_n;
  logic [15:0] q_n;

  // Operand magnitudes
  assign abs_dx = req.dx[DIFF_W-1] ? 18'(-req.dx) : 18'(req.dx);
  assign abs_dz = req.dz[DIFF_W-1] ? 18'(-req.dz) : 18'(req.dz);
  assign s2     = {scale, 1'b0};

  // Shared multiplier
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (state)
      NS_MULX: begin mul_a = 30'(s2); mul_b = 30'(ax); end
      NS_MULZ: begin mul_a = 30'(s2); mul_b = 30'(az); end
      NS_SQX:  begin mul_a = gx[29:0]; mul_b = gx[29:0]; end
      NS_SQY:  begin mul_a = 30'(gy); mul_b = 30'(gy); end
      NS_SQZ:  begin mul_a = gz[29:0]; mul_b = gz[29:0]; end
      default: begin mul_a = '0; mul_b = '0; end
    endcase
  end
  assign mul_p = mul_a * mul_b;

  // Range reduction: both slopes below 2^30
  assign over = (|gx[33:30]) | (|gz[33:30]);

  // Root step
  assign trial   = sq_res + sq_bit;
  assign root_ge = sq_v >= trial;
  assign len     = sq_res[30:0];

  // Division step: (mag * 2^15 + len) / (2 * len)
  always_comb begin
    case (sel)
      2'd0:    mag = gx[29:0];
      2'd1:    mag = 30'(gy);
      default: mag = gz[29:0];
    endcase
  end
  assign num    = (46'(mag) << 15) + 46'(len);
  assign rem_sh = {rem, nlow[15]};
  assign div_d  = {1'b0, len, 1'b0};
  assign div_ge = rem_sh >= div_d;
  assign rem_n  = div_ge ? 32'(rem_sh - div_d) : rem_sh[31:0];
  assign q_n    = {q[14:0], div_ge};

  // State register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= NS_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Next state
  always_comb begin
    state_next = state;
    unique case (state)
      NS_IDLE:  if (start) state_next = NS_MULX;
      NS_MULX:  state_next = NS_MULZ;
      NS_MULZ:  state_next = NS_SHIFT;
      NS_SHIFT: if (!over) state_next = NS_SQX;
      NS_SQX:   state_next = NS_SQY;
      NS_SQY:   state_next = NS_SQZ;
      NS_SQZ:   state_next = NS_ROOT;
      NS_ROOT:  if (sq_bit[0]) state_next = NS_DIVLD;
      NS_DIVLD: state_next = NS_DIV;
      NS_DIV: begin
        if (cnt == 4'd15) state_next = (sel == 2'd2) ? NS_DONE : NS_DIVLD;
      end
      NS_DONE:  state_next = NS_IDLE;
      default:  state_next = NS_IDLE;
    endcase
  end

  // Outputs
  always_comb begin
    done      = (state == NS_DONE);
    rsp.mag_x = rx;
    rsp.mag_y = ry;
    rsp.mag_z = rz;
    rsp.neg_x = neg_x;
    rsp.neg_z = neg_z;
  end

  // Datapath
  always_ff @(posedge clk) begin
    case (state)
      NS_IDLE: begin
        if (start) begin
          neg_x <= req.dx[DIFF_W-1];
          neg_z <= req.dz[DIFF_W-1];
          ax    <= abs_dx[16:0];
          az    <= abs_dz[16:0];
          gy    <= 19'h40000;
          sel   <= 2'd0;
        end
      end
      NS_MULX:  gx <= mul_p[33:0];
      NS_MULZ:  gz <= mul_p[33:0];
      NS_SHIFT: begin
        if (over) begin
          gx <= gx >> 1;
          gz <= gz >> 1;
          gy <= gy >> 1;
        end
      end
      NS_SQX:   acc <= 62'(mul_p);
      NS_SQY:   acc <= acc + 62'(mul_p);
      NS_SQZ: begin
        sq_v   <= acc + 62'(mul_p);
        sq_res <= '0;
        sq_bit <= 62'd1 << 60;
      end
      NS_ROOT: begin
        if (root_ge) begin
          sq_v   <= sq_v - trial;
          sq_res <= (sq_res >> 1) + sq_bit;
        end else begin
          sq_res <= sq_res >> 1;
        end
        sq_bit <= sq_bit >> 2;
      end
      NS_DIVLD: begin
        rem  <= 32'(num[45:16]);
        nlow <= num[15:0];
        q    <= '0;
        cnt  <= '0;
      end
      NS_DIV: begin
        rem  <= rem_n;
        nlow <= nlow << 1;
        q    <= q_n;
        cnt  <= cnt + 4'd1;
        if (cnt == 4'd15) begin
          case (sel)
            2'd0:    rx <= q_n[MAG_W-1:0];
            2'd1:    ry <= q_n[MAG_W-1:0];
            default: rz <= q_n[MAG_W-1:0];
          endcase
          sel <= sel + 2'd1;
        end
      end
      default: ;
    endcase
  end

endmodule

@@ rtl/core/heightmap_normal_stream.sv @@
// ----------------------------------------------------------------------------
// heightmap_normal_stream: unit normals from a raster heightmap stream
// A sample yields up to four normals, each computed in turn by the shared unit
//   (range reduction takes 0 to 4 shifts); output stalls hold the sequencer.
// The shared unit takes a new request only when done: 31 root steps plus
//   three 16-step divides.
// Reset clears counters, window, handshakes and loads the register defaults.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "heightmap_normal_stream_assert.svh"

module heightmap_normal_stream (
  input  logic                               clk,
  input  logic                               rst,
  // configuration
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  logic [hns_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [hns_pkg::CFG_DATA_W-1:0]     cfg_data,
  // samples
  input  logic                               sample_valid,
  output logic                               sample_stall,
  input  logic signed [hns_pkg::SAMPLE_W-1:0] height_sample,
  // normals
  output logic                               normal_valid,
  input  logic                               normal_stall,
  output logic signed [hns_pkg::NORM_W-1:0]  normal_x,
  output logic [hns_pkg::MAG_W-1:0]          normal_y,
  output logic signed [hns_pkg::NORM_W-1:0]  normal_z,
  output logic [hns_pkg::COL_W-1:0]          pos_col,
  output logic [hns_pkg::ROW_W-1:0]          pos_row,
  output logic                               run_last,
  output logic                               frame_end
);
  import hns_pkg::*;

  seq_state_t state, state_next;

  logic [MW_W-1:0]    map_width;
  logic [MH_W-1:0]    map_height;
  logic [SCALE_W-1:0] normal_scale;

  logic [COL_W-1:0] col_counter, cur_c, c_clamp, w_m1, pos_x;
  logic [ROW_W-1:0] row_counter, cur_r, r_clamp, h_m1;
  logic signed [SAMPLE_W-1:0] win0, win1, cur_v;
  logic signed [SAMPLE_W-1:0] mx, mc, axm, ax_r, ac;
  logic [3:0] jobs;
  logic [1:0] job_k, pick_k;

  logic c1, lc, lr, x0, r_is1;
  logic slot_free, load_out;

  logic                  a_we, m_we;
  logic [COL_W-1:0]      a_waddr, m_waddr, a_raddr, m_raddr;
  logic [SAMPLE_W-1:0]   a_wdata, m_wdata, a_rdata, m_rdata;

  logic      norm_start, norm_done;
  norm_req_t norm_req;
  norm_rsp_t norm_rsp;

  logic signed [19:0] e_v, e_w0, e_w1, e_mx, e_mc, e_axm, e_ax, e_ac;
  logic signed [19:0] zl0, zu0, zl1, zu2, dx_sel, dz_sel;

  // Line stores
  hns_ram #(.WIDTH(SAMPLE_W), .DEPTH(MAX_WIDTH)) u_row_above (
    .clk, .we(a_we), .waddr(a_waddr), .wdata(a_wdata), .raddr(a_raddr), .rdata(a_rdata)
  );
  hns_ram #(.WIDTH(SAMPLE_W), .DEPTH(MAX_WIDTH)) u_row_middle (
    .clk, .we(m_we), .waddr(m_waddr), .wdata(m_wdata), .raddr(m_raddr), .rdata(m_rdata)
  );

  // Shared normalization unit
  hns_norm u_norm (
    .clk, .rst, .start(norm_start), .req(norm_req), .scale(normal_scale),
    .done(norm_done), .rsp(norm_rsp)
  );

  // Configuration registers
  assign cfg_ready = 1'b1;
  always_ff @(posedge clk) begin
    if (rst) begin
      map_width    <= WIDTH_RESET;
      map_height   <= HEIGHT_RESET;
      normal_scale <= SCALE_RESET;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_MAP_WIDTH:    map_width    <= cfg_data[MW_W-1:0];
        REG_MAP_HEIGHT:   map_height   <= cfg_data[MH_W-1:0];
        REG_NORMAL_SCALE: normal_scale <= cfg_data;
        default: ;
      endcase
    end
  end

  // Clamped map size and position
  always_comb begin
    if (map_width < MW_W'(2))              w_m1 = COL_W'(1);
    else if (map_width > MW_W'(MAX_WIDTH)) w_m1 = COL_W'(MAX_WIDTH - 1);
    else                                   w_m1 = COL_W'(map_width - MW_W'(1));
    if (map_height < MH_W'(2))               h_m1 = ROW_W'(1);
    else if (map_height > MH_W'(MAX_HEIGHT)) h_m1 = ROW_W'(MAX_HEIGHT - 1);
    else                                     h_m1 = ROW_W'(map_height - MH_W'(1));
  end
  assign c_clamp = (col_counter > w_m1) ? w_m1 : col_counter;
  assign r_clamp = (row_counter > h_m1) ? h_m1 : row_counter;

  // Flags of the item in work
  assign pos_x = cur_c - COL_W'(1);
  assign c1    = (cur_c != '0);
  assign lc    = (cur_c == w_m1);
  assign lr    = (cur_r == h_m1);
  assign x0    = (cur_c == COL_W'(1));
  assign r_is1 = (cur_r == ROW_W'(1));

  // Lowest pending normal
  always_comb begin
    if (jobs[0])      pick_k = 2'd0;
    else if (jobs[1]) pick_k = 2'd1;
    else if (jobs[2]) pick_k = 2'd2;
    else              pick_k = 2'd3;
  end

  // Central differences with border extrapolation
  always_comb begin
    e_v   = 20'(cur_v);
    e_w0  = 20'(win0);
    e_w1  = 20'(win1);
    e_mx  = 20'(mx);
    e_mc  = 20'(mc);
    e_axm = 20'(axm);
    e_ax  = 20'(ax_r);
    e_ac  = 20'(ac);
    zl0 = x0 ? (e_mx + e_mx - e_mc) : e_axm;
    zu0 = r_is1 ? (e_mx + e_mx - e_w0) : e_ax;
    zl1 = x0 ? (e_w0 + e_w0 - e_v) : e_w1;
    zu2 = r_is1 ? (e_mc + e_mc - e_v) : e_ac;
    case (pick_k)
      2'd0: begin dx_sel = zl0 - e_mc;             dz_sel = e_w0 - zu0; end
      2'd1: begin dx_sel = zl1 - e_v;              dz_sel = e_w0 + e_w0 - e_mx - e_mx; end
      2'd2: begin dx_sel = e_mx + e_mx - e_mc - e_mc; dz_sel = e_v - zu2; end
      default: begin dx_sel = e_w0 + e_w0 - e_v - e_v; dz_sel = e_v + e_v - e_mc - e_mc; end
    endcase
    norm_req.dx = dx_sel[DIFF_W-1:0];
    norm_req.dz = dz_sel[DIFF_W-1:0];
  end

  // State register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Next state
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: if (sample_valid) state_next = ST_RD0;
      ST_RD0:  state_next = ST_RD1;
      ST_RD1:  state_next = ST_RD2;
      ST_RD2:  state_next = ST_RD3;
      ST_RD3:  state_next = ST_PICK;
      ST_PICK: state_next = (jobs == '0) ? ST_WR0 : ST_CALC;
      ST_CALC: if (norm_done) state_next = ST_PUSH;
      ST_PUSH: if (slot_free) state_next = ST_PICK;
      ST_WR0:  state_next = ST_WR1;
      ST_WR1:  state_next = ST_IDLE;
      default: state_next = ST_IDLE;
    endcase
  end

  // Control outputs and store ports
  always_comb begin
    sample_stall = (state != ST_IDLE);
    slot_free    = !normal_valid || !normal_stall;
    load_out     = (state == ST_PUSH) && slot_free;
    norm_start   = (state == ST_PICK) && (jobs != '0);
    a_raddr = cur_c;
    m_raddr = cur_c;
    a_we = 1'b0;  a_waddr = cur_c;  a_wdata = mc;
    m_we = 1'b0;  m_waddr = cur_c;  m_wdata = cur_v;
    unique case (state)
      ST_RD0: begin m_raddr = pos_x; a_raddr = pos_x - COL_W'(1); end
      ST_RD1: begin m_raddr = cur_c; a_raddr = pos_x; end
      ST_WR0: begin
        a_we = c1;  a_waddr = pos_x;  a_wdata = mx;
        m_we = c1;  m_waddr = pos_x;  m_wdata = win0;
      end
      ST_WR1: begin a_we = lc; m_we = lc; end
      default: ;
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      col_counter  <= '0;
      row_counter  <= '0;
      win0         <= '0;
      win1         <= '0;
      jobs         <= '0;
      normal_valid <= 1'b0;
    end else begin
      if (load_out) begin
        normal_valid <= 1'b1;
      end else if (normal_valid && !normal_stall) begin
        normal_valid <= 1'b0;
      end
      if (state == ST_IDLE && sample_valid) begin
        jobs <= {(c_clamp == w_m1) && (r_clamp == h_m1),
                 (c_clamp == w_m1) && (r_clamp != '0),
                 (c_clamp != '0) && (r_clamp == h_m1),
                 (c_clamp != '0) && (r_clamp != '0)};
      end else if (norm_start) begin
        jobs <= jobs & ~(4'd1 << pick_k);
      end
      if (state == ST_WR1) begin
        win1 <= win0;
        win0 <= cur_v;
        if (lc) begin
          col_counter <= '0;
          row_counter <= lr ? '0 : cur_r + ROW_W'(1);
        end else begin
          col_counter <= cur_c + COL_W'(1);
          row_counter <= cur_r;
        end
      end
    end
  end

  // Item capture, store reads and result transfer register
  always_ff @(posedge clk) begin
    if (state == ST_IDLE && sample_valid) begin
      cur_c <= c_clamp;
      cur_r <= r_clamp;
      cur_v <= height_sample;
    end
    case (state)
      ST_RD1: begin mx <= m_rdata; axm <= a_rdata; end
      ST_RD2: begin mc <= m_rdata; ax_r <= a_rdata; end
      ST_RD3: ac <= a_rdata;
      default: ;
    endcase
    if (norm_start) begin
      job_k <= pick_k;
    end
    if (load_out) begin
      normal_x  <= norm_rsp.neg_x ? NORM_W'(0) - NORM_W'(norm_rsp.mag_x)
                                  : NORM_W'(norm_rsp.mag_x);
      normal_y  <= norm_rsp.mag_y;
      normal_z  <= norm_rsp.neg_z ? NORM_W'(0) - NORM_W'(norm_rsp.mag_z)
                                  : NORM_W'(norm_rsp.mag_z);
      pos_col   <= job_k[1] ? cur_c : pos_x;
      pos_row   <= job_k[0] ? cur_r : cur_r - ROW_W'(1);
      run_last  <= (jobs == '0);
      frame_end <= (job_k == 2'd3);
    end
  end

  `HNS_ASSERT_NEXT(a_accept_reads, sample_valid && !sample_stall, state == ST_RD0, "accepted sample did not start store reads")
  `HNS_ASSERT_NOW(a_frame_end_last, normal_valid && frame_end, run_last, "frame end not on last result")
  `HNS_ASSERT_NEXT(a_push_holds, state == ST_PUSH && normal_valid && normal_stall, state == ST_PUSH && normal_valid, "result lost while output stalled")
  `HNS_ASSERT_NOW(a_done_in_calc, norm_done, state == ST_CALC, "normal unit finished outside calc")

endmodule
